// ----- design/isodr_pkg.sv -----
// shared constants, codes and helpers of the directory record scanner
package isodr_pkg;

   localparam int DEFAULT_SECTOR_BYTES = 2048;
   localparam int DEFAULT_NAME_CHARS   = 64;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_DATA   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // record layout
   localparam logic [7:0] REC_MIN_LEN  = 8'd34;
   localparam logic [7:0] ID_OFS       = 8'd33;
   localparam logic [7:0] ID_LEN_OFS   = 8'd32;
   localparam logic [7:0] EXTENT_OFS   = 8'd2;
   localparam logic [7:0] LENGTH_OFS   = 8'd10;
   localparam logic [7:0] FLAGS_OFS    = 8'd25;
   localparam int         FLAG_DIR_BIT = 1;

   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_UA   = 8'h41;
   localparam logic [7:0] CHAR_UZ   = 8'h5A;
   localparam logic [7:0] CASE_GAP  = 8'd32;

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= CHAR_UA && c <= CHAR_UZ) ? c + CASE_GAP : c;
   endfunction

endpackage

// ----- design/isodr_if.sv -----
// request and result channel interfaces of the directory record scanner
interface isodr_req_if;
   import isodr_pkg::*;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] value;
   logic       last_of_sector;
   modport source(output valid, operation, value, last_of_sector, input ready);
   modport sink(input valid, operation, value, last_of_sector, output ready);
endinterface

interface isodr_rsp_if;
   import isodr_pkg::*;
   logic        valid;
   logic        ready;
   logic [31:0] extent_lba;
   logic [31:0] data_length;
   logic        is_directory;
   logic        name_matches;
   logic [7:0]  stripped_name_length;
   modport source(output valid, extent_lba, data_length, is_directory, name_matches,
                  stripped_name_length, input ready);
   modport sink(input valid, extent_lba, data_length, is_directory, name_matches,
                stripped_name_length, output ready);
endinterface

// ----- design/iso9660_dir_record_scanner_unit.sv -----
// ISO 9660 directory record scanner: takes one request per cycle while the result side is
// not stalled (load wanted name or feed one directory byte) and returns one entry per
// completed ordinary record. A result passes through the input register and the result
// register after the data byte that closes its record.
// The wanted name sits in a small memory with two registered read ports that are
// prefetched at the next compare position and the one after it, so a pending dot and the
// following character are compared in the same cycle. There is no clearing pass after reset.
module iso9660_dir_record_scanner_unit #(
   parameter int SECTOR_BYTES = isodr_pkg::DEFAULT_SECTOR_BYTES,
   parameter int NAME_CHARS   = isodr_pkg::DEFAULT_NAME_CHARS
) (
   input  logic         clock,
   input  logic         reset,
   isodr_req_if.sink    req_chan,
   isodr_rsp_if.source  rsp_chan
);
   import isodr_pkg::*;

   localparam int OFF_W = $clog2(SECTOR_BYTES);
   localparam int OFF_X = OFF_W + 1;
   localparam int WL_W  = $clog2(NAME_CHARS + 1);
   localparam int IDX_W = $clog2(NAME_CHARS);

   // input register
   logic       stage_valid_ff;
   op_type     stage_op_ff;
   logic [7:0] stage_value_ff;
   logic       stage_last_ff;
   logic       advance;

   // scanner state
   logic [OFF_W-1:0] offset_ff, offset_in;
   logic [7:0]       rel_ff, rel_in;
   logic [7:0]       reclen_ff, reclen_in;
   logic             skip_ff, skip_in;
   logic [7:0]       idlen_ff, idlen_in;
   logic [31:0]      extent_ff, extent_in;
   logic [31:0]      length_ff, length_in;
   logic             dir_ff, dir_in;
   logic [7:0]       ci_ff, ci_in;
   logic             miss_ff, miss_in;
   logic             stop_ff, stop_in;
   logic             pdot_ff, pdot_in;
   logic [7:0]       first_ff, first_in;
   logic [WL_W-1:0]  wlen_ff, wlen_in;

   // name memory
   logic [7:0]       name_mem [NAME_CHARS];
   logic [7:0]       rd0_ff, rd1_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, ra0, ra1;
   logic [8:0]       ci_next_p1;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] out_extent_ff, out_length_ff;
   logic        out_dir_ff, out_match_ff;
   logic [7:0]  out_strip_ff;
   logic        produce;

   // combinational helpers
   logic             is_data;
   logic [OFF_X-1:0] off_x;
   logic [7:0]       b, ext_rel, len_rel, id_k;
   logic             id_last, in_id, dot_used, fits, dots, sector_end;

   function automatic logic char_miss(input logic [7:0] idx, input logic [WL_W-1:0] wl,
                                      input logic [7:0] stored, input logic [7:0] c);
      return ({1'b0, idx} >= 9'(wl)) || (fold(stored) != fold(c));
   endfunction

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
   endfunction

   assign advance        = stage_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !stage_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         stage_valid_ff <= req_chan.valid;
      end
      if (req_chan.valid && req_chan.ready) begin
         stage_op_ff    <= op_type'(req_chan.operation);
         stage_value_ff <= req_chan.value;
         stage_last_ff  <= req_chan.last_of_sector;
      end
   end

   assign is_data = advance && stage_op_ff == OP_DATA;
   assign b       = stage_value_ff;
   assign off_x   = {1'b0, offset_ff};
   assign ext_rel = rel_ff - EXTENT_OFS;
   assign len_rel = rel_ff - LENGTH_OFS;
   assign id_k    = rel_ff - ID_OFS;
   assign id_last = (id_k + 8'd1) == idlen_ff;
   assign in_id   = rel_ff >= ID_OFS && {1'b0, rel_ff} < ({1'b0, ID_OFS} + {1'b0, idlen_ff});
   assign sector_end = stage_last_ff || (off_x == OFF_X'(SECTOR_BYTES - 1));

   // name loading
   assign wr_en   = advance && stage_op_ff == OP_APPEND && 9'(wlen_ff) < 9'(NAME_CHARS);
   assign wr_addr = wlen_ff[IDX_W-1:0];

   always_comb begin
      wlen_in = wlen_ff;
      if (advance && stage_op_ff == OP_CLEAR) begin
         wlen_in = '0;
      end else if (wr_en) begin
         wlen_in = wlen_ff + WL_W'(1);
      end
   end

   // directory byte processing
   always_comb begin
      offset_in = offset_ff;
      rel_in    = rel_ff;
      reclen_in = reclen_ff;
      skip_in   = skip_ff;
      idlen_in  = idlen_ff;
      extent_in = extent_ff;
      length_in = length_ff;
      dir_in    = dir_ff;
      ci_in     = ci_ff;
      miss_in   = miss_ff;
      stop_in   = stop_ff;
      pdot_in   = pdot_ff;
      first_in  = first_ff;
      dot_used  = 1'b0;
      fits      = 1'b0;
      dots      = 1'b0;
      produce   = 1'b0;
      if (is_data) begin
         if (!skip_ff) begin
            if (reclen_ff == 8'd0) begin
               if (b < REC_MIN_LEN || off_x + OFF_X'(ID_OFS) > OFF_X'(SECTOR_BYTES) ||
                   off_x + OFF_X'(b) > OFF_X'(SECTOR_BYTES)) begin
                  skip_in = 1'b1;
               end else begin
                  reclen_in = b;
                  rel_in    = 8'd1;
                  idlen_in  = '0;
                  extent_in = '0;
                  length_in = '0;
                  dir_in    = 1'b0;
                  ci_in     = '0;
                  miss_in   = 1'b0;
                  stop_in   = 1'b0;
                  pdot_in   = 1'b0;
                  first_in  = '0;
               end
            end else begin
               rel_in = rel_ff + 8'd1;
               if (rel_ff >= EXTENT_OFS && rel_ff < EXTENT_OFS + 8'd4) begin
                  extent_in[8*ext_rel[1:0] +: 8] = b;
               end else if (rel_ff >= LENGTH_OFS && rel_ff < LENGTH_OFS + 8'd4) begin
                  length_in[8*len_rel[1:0] +: 8] = b;
               end else if (rel_ff == FLAGS_OFS) begin
                  dir_in = b[FLAG_DIR_BIT];
               end else if (rel_ff == ID_LEN_OFS) begin
                  idlen_in = b;
               end else if (in_id) begin
                  if (id_k == 8'd0) begin
                     first_in = b;
                  end
                  if (!stop_ff) begin
                     // a held dot counts only if no version suffix follows it
                     if (pdot_ff) begin
                        pdot_in = 1'b0;
                        if (b != CHAR_SEMI) begin
                           miss_in  = miss_in | char_miss(ci_ff, wlen_ff, rd0_ff, CHAR_DOT);
                           ci_in    = sat_inc(ci_ff);
                           dot_used = 1'b1;
                        end
                     end
                     if (b == CHAR_SEMI) begin
                        stop_in = 1'b1;
                     end else if (b == CHAR_DOT) begin
                        if (id_last) begin
                           stop_in = 1'b1;
                        end else begin
                           pdot_in = 1'b1;
                        end
                     end else begin
                        miss_in = miss_in | char_miss(ci_in, wlen_ff,
                                                      dot_used ? rd1_ff : rd0_ff, b);
                        ci_in   = sat_inc(ci_in);
                     end
                  end
               end
               if ((rel_ff + 8'd1) == reclen_ff) begin
                  fits      = ({1'b0, ID_OFS} + {1'b0, idlen_in}) <= {1'b0, reclen_ff};
                  dots      = idlen_in == 8'd1 && first_in <= 8'd1;
                  produce   = fits && !dots;
                  reclen_in = '0;
               end
            end
         end
         if (sector_end) begin
            offset_in = '0;
            reclen_in = '0;
            skip_in   = 1'b0;
         end else begin
            offset_in = offset_ff + OFF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         rel_ff    <= '0;
         reclen_ff <= '0;
         skip_ff   <= 1'b0;
         idlen_ff  <= '0;
         extent_ff <= '0;
         length_ff <= '0;
         dir_ff    <= 1'b0;
         ci_ff     <= '0;
         miss_ff   <= 1'b0;
         stop_ff   <= 1'b0;
         pdot_ff   <= 1'b0;
         first_ff  <= '0;
         wlen_ff   <= '0;
      end else begin
         offset_ff <= offset_in;
         rel_ff    <= rel_in;
         reclen_ff <= reclen_in;
         skip_ff   <= skip_in;
         idlen_ff  <= idlen_in;
         extent_ff <= extent_in;
         length_ff <= length_in;
         dir_ff    <= dir_in;
         ci_ff     <= ci_in;
         miss_ff   <= miss_in;
         stop_ff   <= stop_in;
         pdot_ff   <= pdot_in;
         first_ff  <= first_in;
         wlen_ff   <= wlen_in;
      end
   end

   // prefetch the entries at the next compare position and the one after it
   assign ci_next_p1 = {1'b0, ci_in} + 9'd1;
   assign ra0        = ci_in[IDX_W-1:0];
   assign ra1        = ci_next_p1[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         name_mem[wr_addr] <= b;
      end
      rd0_ff <= (wr_en && wr_addr == ra0) ? b : name_mem[ra0];
      rd1_ff <= (wr_en && wr_addr == ra1) ? b : name_mem[ra1];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= produce;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && produce) begin
         out_extent_ff <= extent_in;
         out_length_ff <= length_in;
         out_dir_ff    <= dir_in;
         out_match_ff  <= !miss_in && (9'(ci_in) == 9'(wlen_ff));
         out_strip_ff  <= ci_in;
      end
   end

   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.extent_lba           = out_extent_ff;
   assign rsp_chan.data_length          = out_length_ff;
   assign rsp_chan.is_directory         = out_dir_ff;
   assign rsp_chan.name_matches         = out_match_ff;
   assign rsp_chan.stripped_name_length = out_strip_ff;

endmodule

// ----- design/isodr_checker.sv -----
// port-level checks of the directory record scanner, bound to its top level
module isodr_checker #(
   parameter int NAME_CHARS = isodr_pkg::DEFAULT_NAME_CHARS
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_extent_lba,
   input logic [31:0] rsp_data_length,
   input logic        rsp_name_matches,
   input logic [7:0]  rsp_stripped_name_length
);
   import isodr_pkg::*;

   // pipeline comes out of reset empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("scanner not empty after reset");

   // a new entry is always caused by an accepted directory byte request
   a_entry_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_operation == OP_DATA, 2))
      else $error("entry without a directory byte request");

   // a match never claims more characters than the name can hold
   a_match_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_name_matches |-> 9'(rsp_stripped_name_length) <= 9'(NAME_CHARS))
      else $error("match longer than the wanted name store");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_extent_lba)
                                 && $stable(rsp_data_length))
      else $error("stalled entry changed");

endmodule

bind iso9660_dir_record_scanner_unit isodr_checker #(.NAME_CHARS(NAME_CHARS)) u_isodr_checker (
   .clock                    (clock),
   .reset                    (reset),
   .req_valid                (req_chan.valid),
   .req_ready                (req_chan.ready),
   .req_operation            (req_chan.operation),
   .rsp_valid                (rsp_chan.valid),
   .rsp_ready                (rsp_chan.ready),
   .rsp_extent_lba           (rsp_chan.extent_lba),
   .rsp_data_length          (rsp_chan.data_length),
   .rsp_name_matches         (rsp_chan.name_matches),
   .rsp_stripped_name_length (rsp_chan.stripped_name_length)
);
